// ===== hw/rtl/vldg_pkg.sv =====
// Shared types and constants for the vector line dot generator.
`timescale 1ns / 1ps
`default_nettype none

package vldg_pkg;

    // Full-scale coordinates that map to DAC code 255
    localparam int MAX_X_DEF = 33000;
    localparam int MAX_Y_DEF = 41000;

    localparam int COORD_W = 16;
    localparam int CUR_W   = 17;
    localparam int ERR_W   = 19;
    localparam int DAC_W   = 8;

    // Request kinds carried on s_tuser
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_NORM,
        ST_MULT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;     // take the request into the item registers
        logic step;        // load or advance the line state
        logic latch_last;  // register the last-dot flag, update line_active
        logic load_out;    // move the scaled dot into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;        // the captured request produces a dot
    } dp_status_t;

endpackage : vldg_pkg

`default_nettype wire

// ===== hw/rtl/vldg_scale.sv =====
// Two-stage constant scaler: min(255, value*255/DIVISOR) by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module vldg_scale
    import vldg_pkg::*;
#(
    parameter int DIVISOR = MAX_X_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CUR_W-1:0]   value,
    output logic      [DAC_W-1:0]   code
);

    localparam int NumW  = CUR_W + DAC_W;      // value*255 fits here
    localparam int Shift = NumW;
    localparam int RecW  = Shift + 1;
    localparam int ProdW = NumW + RecW;
    localparam logic [RecW-1:0]    Recip = RecW'((64'(1) << Shift) / DIVISOR);
    localparam logic [COORD_W-1:0] DivW  = COORD_W'(DIVISOR);
    localparam int QdW = DAC_W + COORD_W;

    logic [NumW-1:0]  n_reg, n_next;
    logic [NumW-1:0]  n_d_reg;
    logic [ProdW-1:0] prod_reg, prod_next;

    logic [RecW-1:0]  q0_w;
    logic             sat_w;
    logic [DAC_W-1:0] q8_w;
    logic [QdW-1:0]   qd_w;
    logic [NumW-1:0]  rem_w;
    logic [DAC_W:0]   q_fix_w;

    // value*255 as value*256 - value
    assign n_next    = {value, {DAC_W{1'b0}}} - {{DAC_W{1'b0}}, value};
    assign prod_next = ProdW'(n_reg) * ProdW'(Recip);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            n_d_reg  <= '0;
            prod_reg <= '0;
        end else begin
            n_reg    <= n_next;
            n_d_reg  <= n_reg;
            prod_reg <= prod_next;
        end
    end

    // Estimate is the true quotient or one below it
    assign q0_w  = prod_reg[ProdW-1:Shift];
    assign sat_w = (q0_w > RecW'(2**DAC_W - 1));
    assign q8_w  = q0_w[DAC_W-1:0];
    assign qd_w  = QdW'(q8_w) * QdW'(DivW);
    assign rem_w = n_d_reg - NumW'(qd_w);

    always_comb begin
        q_fix_w = {1'b0, q8_w};
        if (rem_w >= NumW'(DivW)) begin
            q_fix_w = {1'b0, q8_w} + (DAC_W+1)'(1);
        end
        if (sat_w || q_fix_w[DAC_W]) begin
            code = {DAC_W{1'b1}};
        end else begin
            code = q_fix_w[DAC_W-1:0];
        end
    end

    // The reciprocal estimate is never more than one short
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !sat_w |-> (rem_w < (NumW'(DivW) << 1)))
        else $error("scaler remainder out of range");

    a_rem_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !sat_w |-> (NumW'(qd_w) <= n_d_reg))
        else $error("scaler estimate above true quotient");

    a_sat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_w |-> (code == {DAC_W{1'b1}}))
        else $error("scaler saturation lost");

endmodule : vldg_scale

`default_nettype wire

// ===== hw/rtl/vldg_datapath.sv =====
// Line state, Bresenham step logic, DAC scaling and output payload register.
`timescale 1ns / 1ps
`default_nettype none

module vldg_datapath
    import vldg_pkg::*;
#(
    parameter int MAX_X = MAX_X_DEF,
    parameter int MAX_Y = MAX_Y_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ctrl_cmd_t           cmd,
    input  wire logic                func,
    input  wire logic [COORD_W-1:0]  x_start,
    input  wire logic [COORD_W-1:0]  y_start,
    input  wire logic [COORD_W-1:0]  x_end,
    input  wire logic [COORD_W-1:0]  y_end,
    output dp_status_t               status,
    output logic      [DAC_W-1:0]    dac_x,
    output logic      [DAC_W-1:0]    dac_y,
    output logic                     last_dot
);

    localparam logic [CUR_W-1:0] MaxYW = CUR_W'(MAX_Y);

    // Captured request
    logic               func_reg;
    logic [COORD_W-1:0] xs_reg, ys_reg, xe_reg, ye_reg;

    // Line state
    logic [CUR_W-1:0]        cur_x_reg, cur_x_next;
    logic [CUR_W-1:0]        cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]      major_end_reg, major_end_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [COORD_W-1:0]      dmaj_reg, dmaj_next;
    logic [COORD_W-1:0]      dmin_reg, dmin_next;
    logic                    x_major_reg, x_major_next;
    logic                    minor_up_reg, minor_up_next;
    logic                    line_active_reg, line_active_next;

    // Output payload
    logic [DAC_W-1:0] dac_x_reg, dac_y_reg;
    logic             last_reg;
    logic             last_dot_reg;

    // Load path
    logic signed [COORD_W:0] dx_w, dy_w;
    logic [COORD_W-1:0]      adx_w, ady_w, ld_dmaj_w, ld_dmin_w;
    logic                    dx_pos_w, dy_pos_w, ld_xmaj_w, swap_w;

    // Advance path
    logic                    step_minor_w;
    logic [CUR_W-1:0]        major_cur_w, minor_cur_w, major_inc_w, minor_new_w;
    logic signed [ERR_W-1:0] err_inc_w;

    logic             last_w;
    logic [CUR_W-1:0] vy_w;
    logic [DAC_W-1:0] code_x_w, code_y_w;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func;
            xs_reg   <= x_start;
            ys_reg   <= y_start;
            xe_reg   <= x_end;
            ye_reg   <= y_end;
        end
    end

    assign dx_w     = $signed({1'b0, xe_reg}) - $signed({1'b0, xs_reg});
    assign dy_w     = $signed({1'b0, ye_reg}) - $signed({1'b0, ys_reg});
    assign adx_w    = dx_w[COORD_W] ? COORD_W'(-dx_w) : dx_w[COORD_W-1:0];
    assign ady_w    = dy_w[COORD_W] ? COORD_W'(-dy_w) : dy_w[COORD_W-1:0];
    assign dx_pos_w = !dx_w[COORD_W] && (dx_w != '0);
    assign dy_pos_w = !dy_w[COORD_W] && (dy_w != '0);
    assign ld_xmaj_w = (ady_w <= adx_w);
    assign swap_w    = ld_xmaj_w ? dx_w[COORD_W] : dy_w[COORD_W];
    assign ld_dmaj_w = ld_xmaj_w ? adx_w : ady_w;
    assign ld_dmin_w = ld_xmaj_w ? ady_w : adx_w;

    // X-major steps on err >= 0, Y-major only on err > 0
    assign step_minor_w = x_major_reg ? !err_reg[ERR_W-1]
                                      : (!err_reg[ERR_W-1] && (err_reg != '0));
    assign major_cur_w = x_major_reg ? cur_x_reg : cur_y_reg;
    assign minor_cur_w = x_major_reg ? cur_y_reg : cur_x_reg;
    assign major_inc_w = major_cur_w + CUR_W'(1);

    always_comb begin
        minor_new_w = minor_cur_w;
        if (step_minor_w) begin
            minor_new_w = minor_up_reg ? minor_cur_w + CUR_W'(1)
                                       : minor_cur_w - CUR_W'(1);
        end
    end

    assign err_inc_w = step_minor_w
        ? ($signed({2'b0, dmin_reg, 1'b0}) - $signed({2'b0, dmaj_reg, 1'b0}))
        : $signed({2'b0, dmin_reg, 1'b0});

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_next       = err_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        x_major_next   = x_major_reg;
        minor_up_next  = minor_up_reg;
        if (cmd.step) begin
            if (func_reg == FUNC_LOAD) begin
                minor_up_next  = (dx_w[COORD_W] && dy_w[COORD_W]) || (dx_pos_w && dy_pos_w);
                x_major_next   = ld_xmaj_w;
                dmaj_next      = ld_dmaj_w;
                dmin_next      = ld_dmin_w;
                major_end_next = ld_xmaj_w ? (swap_w ? xs_reg : xe_reg)
                                           : (swap_w ? ys_reg : ye_reg);
                cur_x_next     = {1'b0, swap_w ? xe_reg : xs_reg};
                cur_y_next     = {1'b0, swap_w ? ye_reg : ys_reg};
                err_next       = $signed({2'b0, ld_dmin_w, 1'b0})
                               - $signed({3'b0, ld_dmaj_w});
            end else begin
                if (x_major_reg) begin
                    cur_x_next = major_inc_w;
                    cur_y_next = minor_new_w;
                end else begin
                    cur_y_next = major_inc_w;
                    cur_x_next = minor_new_w;
                end
                err_next = err_reg + err_inc_w;
            end
        end
    end

    assign last_w = (major_cur_w == {1'b0, major_end_reg});

    always_comb begin
        line_active_next = line_active_reg;
        if (cmd.latch_last) begin
            line_active_next = !last_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            err_reg         <= '0;
            dmaj_reg        <= '0;
            dmin_reg        <= '0;
            x_major_reg     <= 1'b0;
            minor_up_reg    <= 1'b0;
            line_active_reg <= 1'b0;
        end else begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            err_reg         <= err_next;
            dmaj_reg        <= dmaj_next;
            dmin_reg        <= dmin_next;
            x_major_reg     <= x_major_next;
            minor_up_reg    <= minor_up_next;
            line_active_reg <= line_active_next;
        end
    end

    assign status.emit = (func_reg == FUNC_LOAD) || line_active_reg;

    // Vertical axis is inverted; at or past full scale it pins to zero
    assign vy_w = (cur_y_reg >= MaxYW) ? '0 : MaxYW - cur_y_reg;

    vldg_scale #(.DIVISOR(MAX_X)) u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value   (cur_x_reg),
        .code    (code_x_w)
    );

    vldg_scale #(.DIVISOR(MAX_Y)) u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value   (vy_w),
        .code    (code_y_w)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch_last) begin
            last_reg <= last_w;
        end
        if (cmd.load_out) begin
            dac_x_reg    <= code_x_w;
            dac_y_reg    <= code_y_w;
            last_dot_reg <= last_reg;
        end
    end

    assign dac_x    = dac_x_reg;
    assign dac_y    = dac_y_reg;
    assign last_dot = last_dot_reg;

    a_major_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (major_cur_w <= {1'b0, major_end_reg}))
        else $error("major coordinate ran past the line end");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch_last && last_w |=> !line_active_reg)
        else $error("line stayed active after its last dot");

    a_idle_advance_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && (func_reg == FUNC_ADVANCE) && !line_active_reg
        |=> $stable(cur_x_reg) && $stable(cur_y_reg))
        else $error("advance without a line moved the dot");

endmodule : vldg_datapath

`default_nettype wire

// ===== hw/rtl/vldg_ctrl.sv =====
// Sequencing state machine and result-valid register.
`timescale 1ns / 1ps
`default_nettype none

module vldg_ctrl
    import vldg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire dp_status_t  status,
    output ctrl_cmd_t        cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free_w;

    assign out_free_w = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = status.emit ? ST_NORM : ST_IDLE;
            end
            ST_NORM: state_next = ST_MULT;
            ST_MULT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free_w) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_CALC: cmd.step       = status.emit;
            ST_NORM: cmd.latch_last = 1'b1;
            ST_MULT: ;
            ST_DONE: cmd.load_out   = out_free_w;
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_CALC)
        else $error("accepted request did not start");

    a_scale_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NORM |=> state_reg == ST_MULT ##1 state_reg == ST_DONE)
        else $error("scaler sequence broken");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_tvalid_reg && !m_tready))
        else $error("pending result overwritten");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

endmodule : vldg_ctrl

`default_nettype wire

// ===== hw/rtl/vector_line_dot_generator.sv =====
// Top level of the vector line dot generator: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Walks a Bresenham line one dot per request and emits 8-bit DAC codes for an
// X/Y display. A load request (s_tuser = 0) takes two endpoints from s_tdata and
// emits the first dot; an advance request (s_tuser = 1) emits the next dot, or
// nothing when no line is active. m_tlast marks a line's final dot. One request
// is handled at a time: a request that gives a dot passes the line step, the
// last-dot check with the first scaler stage, the second scaler stage and
// the output register before m_tvalid rises, and only then does the input
// take the next request. An advance with no active line frees the input as
// soon as it finds that no line is active, without scaling a dot. The next
// request is taken as soon as the dot sits in the output register, while it
// still waits for m_tready; a following dot then holds in its last step until
// the output register is free.
module vector_line_dot_generator
    import vldg_pkg::*;
#(
    parameter int MAX_X = MAX_X_DEF,
    parameter int MAX_Y = MAX_Y_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // x_start, y_start, x_end, y_end
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // dac_x, dac_y
    output logic             m_tlast
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [DAC_W-1:0] dac_x, dac_y;

    vldg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vldg_datapath #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .func     (s_tuser),
        .x_start  (s_tdata[15:0]),
        .y_start  (s_tdata[31:16]),
        .x_end    (s_tdata[47:32]),
        .y_end    (s_tdata[63:48]),
        .status   (status),
        .dac_x    (dac_x),
        .dac_y    (dac_y),
        .last_dot (m_tlast)
    );

    assign m_tdata = {dac_y, dac_x};

endmodule : vector_line_dot_generator

`default_nettype wire
